/* rtl/utfx_pkg.sv */
// Shared types, format codes and encode helpers for the UTF transcoder.
`default_nettype none
package utfx_pkg;

   // Source format codes (code 3 decodes as UTF-32)
   localparam logic [1:0] SRC_UTF8  = 2'd0;
   localparam logic [1:0] SRC_UTF16 = 2'd1;
   localparam logic [1:0] SRC_UTF32 = 2'd2;

   // Target format codes
   localparam logic [1:0] TGT_UTF8  = 2'd0;
   localparam logic [1:0] TGT_UTF16 = 2'd1;
   localparam logic [1:0] TGT_UTF32 = 2'd2;
   localparam logic [1:0] TGT_RAW   = 2'd3;

   // Register index codes (taken from paddr[2])
   localparam logic REG_SOURCE = 1'b0;
   localparam logic REG_TARGET = 1'b1;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [31:0] code_unit;
      logic        end_of_string;
   } req_type;

   typedef struct packed {
      logic [31:0] out_unit;
      logic        unit_valid;
      logic        last_of_run;
      logic        string_done;
      logic        decode_error;
   } rsp_type;

   // One classified input request: data units to encode plus an optional terminator
   typedef struct packed {
      logic [31:0] cp;          // code point to encode
      logic [2:0]  ndata;       // number of encoded units, 0..4
      logic        term;        // closing terminator result follows the data
      logic        term_valid;  // terminator carries unit_valid (raw error close)
      logic        err;         // terminator flags a decode error
      logic        raw_done;    // last data unit closes the string (raw target)
   } job_type;

   // Number of units the target form needs for one code point (0 = unencodable)
   function automatic logic [2:0] enc_count(input logic [31:0] cp, input logic [1:0] tgt);
      logic [2:0] n;
      n = 3'd0;
      case (tgt)
         TGT_UTF8: begin
            if (cp <= 32'h7F) n = 3'd1;
            else if (cp <= 32'h7FF) n = 3'd2;
            else if (cp <= 32'hFFFF) n = 3'd3;
            else if (cp <= 32'h10FFFF) n = 3'd4;
         end
         TGT_UTF16: begin
            if (cp < 32'hD800 || (cp >= 32'hE000 && cp <= 32'hFFFF)) n = 3'd1;
            else if (cp >= 32'h10000 && cp <= 32'h10FFFF) n = 3'd2;
         end
         default: n = 3'd1;
      endcase
      return n;
   endfunction

   // Byte i of an n-byte UTF-8 sequence
   function automatic logic [7:0] utf8_byte(input logic [31:0] cp, input logic [2:0] n,
                                            input logic [2:0] i);
      logic [7:0] b;
      case (n)
         3'd2: b = (i == 3'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
         3'd3: begin
            case (i)
               3'd0:    b = {4'b1110, cp[15:12]};
               3'd1:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         3'd4: begin
            case (i)
               3'd0:    b = {5'b11110, cp[20:18]};
               3'd1:    b = {2'b10, cp[17:12]};
               3'd2:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         default: b = cp[7:0];
      endcase
      return b;
   endfunction

   // Unit i of the encoding of cp in the target form
   function automatic logic [31:0] enc_unit(input logic [31:0] cp, input logic [1:0] tgt,
                                            input logic [2:0] n, input logic [2:0] i);
      logic [31:0] u;
      logic [20:0] v;
      v = cp[20:0] - 21'h10000;
      case (tgt)
         TGT_UTF8: u = {24'd0, utf8_byte(cp, n, i)};
         TGT_UTF16: begin
            if (n == 3'd1) u = cp;
            else if (i == 3'd0) u = {16'd0, 6'b110110, v[19:10]};
            else u = {16'd0, 6'b110111, cp[9:0]};
         end
         default: u = cp;
      endcase
      return u;
   endfunction

endpackage
`default_nettype wire

/* rtl/utfx_front.sv */
// Front end: decodes source units into code points and classifies each request.
`default_nettype none
module utfx_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  src_clear,
   input  wire [1:0]            source_format,
   input  wire [1:0]            target_format,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  utfx_pkg::req_type    req_data,
   input  wire                  q_full,
   output logic                 push,
   output utfx_pkg::job_type    job
);
   import utfx_pkg::*;

   logic [20:0] accum_ff, accum_in;
   logic [1:0]  remain_ff, remain_in;
   logic [9:0]  held_ff, held_in;
   logic        pend_ff, pend_in;
   logic        halted_ff, halted_in;

   logic        accept, eos, have, err, ended;
   logic [31:0] cp;
   logic [7:0]  b;
   logic [15:0] u;

   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;
   assign eos       = req_data.end_of_string;
   assign b         = req_data.code_unit[7:0];
   assign u         = req_data.code_unit[15:0];

   // Decode one unit and build the job
   always_comb begin
      accum_in  = accum_ff;
      remain_in = remain_ff;
      held_in   = held_ff;
      pend_in   = pend_ff;
      halted_in = halted_ff;
      have      = 1'b0;
      err       = 1'b0;
      ended     = 1'b0;
      cp        = 32'd0;
      job       = '0;
      push      = 1'b0;

      if (!halted_ff) begin
         case (source_format)
            SRC_UTF8: begin
               if (remain_ff != 2'd0) begin
                  accum_in  = {accum_ff[14:0], b[5:0]};
                  remain_in = remain_ff - 2'd1;
                  if (remain_ff == 2'd1) begin
                     cp   = {11'd0, accum_in};
                     have = 1'b1;
                  end
               end else if (b <= 8'h7F) begin
                  cp   = {24'd0, b};
                  have = 1'b1;
               end else if (b <= 8'hBF) begin
                  err = 1'b1;
               end else if (b <= 8'hDF) begin
                  accum_in  = {16'd0, b[4:0]};
                  remain_in = 2'd1;
               end else if (b <= 8'hEF) begin
                  accum_in  = {17'd0, b[3:0]};
                  remain_in = 2'd2;
               end else if (b <= 8'hF7) begin
                  accum_in  = {18'd0, b[2:0]};
                  remain_in = 2'd3;
               end else begin
                  err = 1'b1;
               end
               if (!err && eos && remain_in != 2'd0) err = 1'b1;
            end
            SRC_UTF16: begin
               if (pend_ff) begin
                  cp      = 32'h0001_0000 + {12'd0, held_ff, u[9:0]};
                  pend_in = 1'b0;
                  have    = 1'b1;
               end else if (u < 16'hD800 || u > 16'hDFFF) begin
                  cp   = {16'd0, u};
                  have = 1'b1;
               end else begin
                  held_in = u[9:0];
                  pend_in = 1'b1;
               end
               if (eos && pend_in) err = 1'b1;
            end
            default: begin
               cp   = req_data.code_unit;
               have = 1'b1;
            end
         endcase

         // Classify into data units and terminator
         job.cp = cp;
         if (err) begin
            job.term       = 1'b1;
            job.term_valid = (target_format == TGT_RAW);
            job.err        = 1'b1;
            ended          = 1'b1;
         end else if (have && target_format != TGT_RAW && cp == 32'd0) begin
            job.term = 1'b1;
            ended    = 1'b1;
         end else begin
            job.ndata = have ? enc_count(cp, target_format) : 3'd0;
            if (eos) begin
               if (target_format == TGT_RAW && job.ndata != 3'd0) job.raw_done = 1'b1;
               else job.term = 1'b1;
               ended = 1'b1;
            end
         end
         push = accept && (job.ndata != 3'd0 || job.term);
      end

      // End of string or early end drops any partial sequence
      if (eos) begin
         accum_in  = '0;
         remain_in = '0;
         held_in   = '0;
         pend_in   = 1'b0;
         halted_in = 1'b0;
      end else if (ended) begin
         accum_in  = '0;
         remain_in = '0;
         held_in   = '0;
         pend_in   = 1'b0;
         halted_in = 1'b1;
      end
   end

   // Decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff  <= '0;
         remain_ff <= '0;
         held_ff   <= '0;
         pend_ff   <= 1'b0;
         halted_ff <= 1'b0;
      end else if (src_clear) begin
         accum_ff  <= '0;
         remain_ff <= '0;
         held_ff   <= '0;
         pend_ff   <= 1'b0;
      end else if (accept) begin
         accum_ff  <= accum_in;
         remain_ff <= remain_in;
         held_ff   <= held_in;
         pend_ff   <= pend_in;
         halted_ff <= halted_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/utfx_queue.sv */
// Short job queue decoupling the front end from the back end.
`default_nettype none
module utfx_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  utfx_pkg::job_type    push_job,
   input  wire                  pop,
   output logic                 full,
   output logic                 head_valid,
   output utfx_pkg::job_type    head_job
);
   import utfx_pkg::*;

   localparam int PtrW = $clog2(QUEUE_DEPTH);

   job_type                 slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]         wr_ff, wr_in;
   logic [PtrW-1:0]         rd_ff, rd_in;
   logic [PtrW:0]           count_ff, count_in;
   logic                    do_pop;

   assign full       = (count_ff == (PtrW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ff];
   assign do_pop     = pop & head_valid;

   // Pointer and fill count update
   always_comb begin
      wr_in    = (push && wr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PtrW'(push);
      rd_in    = (do_pop && rd_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PtrW'(do_pop);
      count_in = count_ff + (PtrW+1)'(push) - (PtrW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Job storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_job;
   end

endmodule
`default_nettype wire

/* rtl/utfx_back.sv */
// Back end: steps through a job's units and drives the registered response.
`default_nettype none
module utfx_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire [1:0]            target_format,
   input  wire                  head_valid,
   input  utfx_pkg::job_type    head_job,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output utfx_pkg::rsp_type    rsp_data
);
   import utfx_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff;
   rsp_type    rsp_ff, rsp_in;
   logic       load, is_last, is_data;
   logic [2:0] total;

   assign total   = head_job.ndata + 3'(head_job.term);
   assign is_last = (idx_ff == total - 3'd1);
   assign is_data = (idx_ff < head_job.ndata);
   assign load    = head_valid && (!valid_ff || !rsp_stall);
   assign pop     = load && is_last;

   // Next response: data unit or terminator
   always_comb begin
      rsp_in = '0;
      if (is_data) begin
         rsp_in.out_unit    = enc_unit(head_job.cp, target_format, head_job.ndata, idx_ff);
         rsp_in.unit_valid  = 1'b1;
         rsp_in.string_done = head_job.raw_done && is_last;
      end else begin
         rsp_in.unit_valid   = head_job.term_valid;
         rsp_in.string_done  = 1'b1;
         rsp_in.decode_error = head_job.err;
      end
      rsp_in.last_of_run = is_last;
      idx_in = pop ? 3'd0 : idx_ff + 3'd1;
   end

   // Unit counter and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) idx_ff <= idx_in;
         if (load) valid_ff <= 1'b1;
         else if (!rsp_stall) valid_ff <= 1'b0;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (load) rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

/* rtl/utf_transcoder.sv */
// Top level of the UTF-8/16/32 transcoder: config registers, front, queue, back.
//
//   channel   direction  handshake               payload
//   req_*     in         req_valid / req_stall    req_type (code_unit, end_of_string)
//   rsp_*     out        rsp_valid / rsp_stall    rsp_type (out_unit and flags)
//   config    in/out     psel/penable/pwrite      source_format @0x0, target_format @0x4
//
// Each request is decoded and classified in the cycle it is accepted; the back end
// then emits one response per cycle unless rsp_stall holds it, 0 to 5 responses per
// request (one per encoded unit plus a terminator; none for ignored or partial
// units), so single-unit requests stream at one per cycle while rsp_stall is low.
// Request stall rises only when the two-entry job queue is full.
// Synchronous active-high reset; no clearing pass is needed.
`default_nettype none
module utf_transcoder (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  utfx_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output utfx_pkg::rsp_type    rsp_data,
   input  wire                  psel,
   input  wire                  penable,
   input  wire                  pwrite,
   input  wire  [2:0]           paddr,
   input  wire  [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import utfx_pkg::*;

   logic [1:0] source_ff, target_ff;
   logic       cfg_wr, src_clear;
   logic       push, pop, q_full, head_valid;
   job_type    push_job, head_job;

   // Configuration registers
   assign pready    = 1'b1;
   assign cfg_wr    = psel & penable & pwrite;
   assign src_clear = cfg_wr && (paddr[2] == REG_SOURCE);

   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff <= SRC_UTF8;
         target_ff <= TGT_UTF16;
      end else if (cfg_wr) begin
         if (paddr[2] == REG_SOURCE) source_ff <= pwdata[1:0];
         else target_ff <= pwdata[1:0];
      end
   end

   assign prdata = (paddr[2] == REG_TARGET) ? {30'd0, target_ff} : {30'd0, source_ff};

   utfx_front u_front (
      .clock         (clock),
      .reset         (reset),
      .src_clear     (src_clear),
      .source_format (source_ff),
      .target_format (target_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .q_full        (q_full),
      .push          (push),
      .job           (push_job)
   );

   utfx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   utfx_back u_back (
      .clock         (clock),
      .reset         (reset),
      .target_format (target_ff),
      .head_valid    (head_valid),
      .head_job      (head_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

`ifndef ASSERT_OFF
   // A decode error always closes the string on the request's final response
   a_err_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.decode_error |-> rsp_data.string_done && rsp_data.last_of_run)
      else $error("decode error response does not close the string");

   // A response without data is a terminator
   a_term_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.unit_valid |-> rsp_data.string_done && rsp_data.out_unit == 32'd0)
      else $error("dataless response is not a clean terminator");

   // Queue never takes a job while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push)
      else $error("job queue overflow");
`endif

endmodule
`default_nettype wire
